/* rtl/evk_pkg.sv */
// ----------------------------------------------------------------------------
// evk_pkg
// shared types and constants of the ethernet / vlan / ip key extractor
// ----------------------------------------------------------------------------
package evk_pkg;

   // ethertype values
   localparam logic [15:0] TYPE_IPV4    = 16'h0800;
   localparam logic [15:0] TYPE_IPV6    = 16'h86DD;
   localparam logic [15:0] TYPE_VLAN_Q  = 16'h8100;
   localparam logic [15:0] TYPE_VLAN_AD = 16'h88A8;
   localparam logic [15:0] TYPE_MIN     = 16'h0600;

   // result status codes
   localparam logic [2:0] ST_KEY_READY = 3'd0;
   localparam logic [2:0] ST_SHORT_L2  = 3'd1;
   localparam logic [2:0] ST_NOT_ETH2  = 3'd2;
   localparam logic [2:0] ST_NOT_IP    = 3'd3;
   localparam logic [2:0] ST_SHORT_L3  = 3'd4;
   localparam logic [2:0] ST_NO_DIR    = 3'd5;

   // port direction codes
   localparam logic [1:0] DIR_UNKNOWN = 2'd0;
   localparam logic [1:0] DIR_WAN     = 2'd1;
   localparam logic [1:0] DIR_LAN     = 2'd2;

   // register map
   localparam int          CSR_ADDR_W          = 3;
   localparam logic [0:0]  CSR_IDX_PORT_DIR    = 1'b0;

   // header geometry
   localparam logic [4:0]   L2_OFFSET    = 5'd14;
   localparam logic [4:0]   MAX_OFFSET   = 5'd22;
   localparam logic [4:0]   TAG_BYTES    = 5'd4;
   localparam logic [5:0]   IPV4_HDR     = 6'd20;
   localparam logic [5:0]   IPV6_HDR     = 6'd40;
   localparam logic [5:0]   POS_MAX      = 6'd63;
   localparam logic [31:0]  ADDR_FILL    = 32'hFFFFFFFF;
   localparam logic [127:0] KEY_ALL_ONES = {4{ADDR_FILL}};

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] ethertype;
      logic [4:0]  hdr_offset;
      logic        is_ipv6;
      logic [63:0] key_high;
      logic [63:0] key_low;
   } rsp_word_type;

   // parser to result register
   typedef struct packed {
      logic         fire;
      rsp_word_type word;
   } evk_result_type;

endpackage

/* rtl/evk_csr.sv */
// ----------------------------------------------------------------------------
// evk_csr
// apb-style register port holding the port direction
// ----------------------------------------------------------------------------
module evk_csr
   import evk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output logic [1:0]            port_direction
);

   logic [1:0] dir_ff;
   logic [1:0] dir_in;
   logic       hit;

   assign hit = csr_paddr[CSR_ADDR_W-1] == CSR_IDX_PORT_DIR;

   always_comb begin
      dir_in = dir_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         dir_in = csr_pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= DIR_UNKNOWN;
      end else begin
         dir_ff <= dir_in;
      end
   end

   assign csr_pready     = 1'b1;
   assign csr_prdata     = hit ? {30'd0, dir_ff} : 32'd0;
   assign port_direction = dir_ff;

endmodule

/* rtl/evk_parser.sv */
// ----------------------------------------------------------------------------
// evk_parser
// per-frame header state and the key / status logic for one byte
// ----------------------------------------------------------------------------
module evk_parser
   import evk_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           byte_fire,
   input  req_word_type   byte_word,
   input  logic [1:0]     port_direction,
   output evk_result_type result
);

   logic [5:0]   pos_ff,  pos_in;
   logic [15:0]  type_ff, type_in;
   logic [4:0]   hoff_ff, hoff_in;
   logic         err_ff,  err_in;
   logic [127:0] key_ff,  key_in;

   logic [5:0]   hoff6;
   logic [5:0]   rel;
   logic [5:0]   rel_m8;
   logic [5:0]   rel_m24;
   logic         cap_en;
   logic [3:0]   cap_idx;
   logic [7:0]   b;
   logic         v6;
   logic [5:0]   need;
   logic [2:0]   status;
   logic         l2_bad;

   assign b       = byte_word.frame_byte;
   assign hoff6   = {1'b0, hoff_ff};
   assign rel     = pos_ff - hoff6;
   assign rel_m8  = rel - 6'd8;
   assign rel_m24 = rel - 6'd24;

   // address byte select
   always_comb begin
      cap_en  = 1'b0;
      cap_idx = 4'd0;
      if (type_ff == TYPE_IPV4) begin
         if (port_direction == DIR_WAN && rel[5:2] == 4'd4) begin
            cap_en  = 1'b1;
            cap_idx = {2'b11, rel[1:0]};
         end else if (port_direction == DIR_LAN && rel[5:2] == 4'd3) begin
            cap_en  = 1'b1;
            cap_idx = {2'b11, rel[1:0]};
         end
      end else if (type_ff == TYPE_IPV6) begin
         if (port_direction == DIR_WAN && rel >= 6'd24 && rel < 6'd40) begin
            cap_en  = 1'b1;
            cap_idx = rel_m24[3:0];
         end else if (port_direction == DIR_LAN && rel >= 6'd8 && rel < 6'd24) begin
            cap_en  = 1'b1;
            cap_idx = rel_m8[3:0];
         end
      end
   end

   // header state update for the byte
   always_comb begin
      pos_in  = pos_ff;
      type_in = type_ff;
      hoff_in = hoff_ff;
      err_in  = err_ff;
      key_in  = key_ff;
      if (byte_fire && pos_ff != POS_MAX) begin
         pos_in = pos_ff + 6'd1;
         if (!err_ff) begin
            if (pos_ff == hoff6 - 6'd2) begin
               type_in = {b, 8'h00};
            end else if (pos_ff == hoff6 - 6'd1) begin
               type_in = {type_ff[15:8], b};
               if (hoff_ff == L2_OFFSET && type_in < TYPE_MIN) begin
                  err_in = 1'b1;
               end else if ((type_in == TYPE_VLAN_Q || type_in == TYPE_VLAN_AD)
                            && hoff_ff != MAX_OFFSET) begin
                  hoff_in = hoff_ff + TAG_BYTES;
               end
            end else if (pos_ff >= hoff6 && cap_en) begin
               for (int i = 0; i < 16; i++) begin
                  if (cap_idx == 4'(i)) begin
                     key_in[127-8*i -: 8] = b;
                  end
               end
            end
         end
      end
   end

   // status from the updated state
   assign v6     = type_in == TYPE_IPV6;
   assign need   = {1'b0, hoff_in} + (v6 ? IPV6_HDR : IPV4_HDR);
   assign l2_bad = status == ST_SHORT_L2 || status == ST_NOT_ETH2;

   always_comb begin
      if (pos_in < {1'b0, hoff_in}) begin
         status = ST_SHORT_L2;
      end else if (err_in) begin
         status = ST_NOT_ETH2;
      end else if (type_in != TYPE_IPV4 && !v6) begin
         status = ST_NOT_IP;
      end else if (port_direction != DIR_WAN && port_direction != DIR_LAN) begin
         status = ST_NO_DIR;
      end else if (pos_in < need) begin
         status = ST_SHORT_L3;
      end else begin
         status = ST_KEY_READY;
      end
   end

   always_comb begin
      result.fire            = byte_fire && byte_word.last_byte;
      result.word.status     = status;
      result.word.ethertype  = l2_bad ? 16'd0 : type_in;
      result.word.hdr_offset = l2_bad ? 5'd0 : hoff_in;
      result.word.is_ipv6    = status == ST_KEY_READY && v6;
      result.word.key_high   = status == ST_KEY_READY ? key_in[127:64] : KEY_ALL_ONES[127:64];
      result.word.key_low    = status == ST_KEY_READY ? key_in[63:0]   : KEY_ALL_ONES[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset || result.fire) begin
         pos_ff  <= 6'd0;
         type_ff <= 16'd0;
         hoff_ff <= L2_OFFSET;
         err_ff  <= 1'b0;
         key_ff  <= KEY_ALL_ONES;
      end else begin
         pos_ff  <= pos_in;
         type_ff <= type_in;
         hoff_ff <= hoff_in;
         err_ff  <= err_in;
         key_ff  <= key_in;
      end
   end

endmodule

/* rtl/eth_vlan_ip_key_extractor_unit.sv */
// ----------------------------------------------------------------------------
// eth_vlan_ip_key_extractor_unit
// parses ethernet ii / vlan / ipv4 / ipv6 headers and builds a 128-bit key
// ----------------------------------------------------------------------------
// an accepted req word passes the input register, then the header logic into the
//   result register
// throughput: one frame byte per cycle while no word stalls
// a word only stalls when it is a last byte and the full result register is stalled
// reset: synchronous; clears both stage valids, the frame state and the
//   port direction (unknown)
module eth_vlan_ip_key_extractor_unit
   import evk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // byte input channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_word,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_word,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // input register stage
   logic           in_valid_ff, in_valid_in;
   req_word_type   in_word_ff;

   // result register stage
   logic           out_valid_ff, out_valid_in;
   rsp_word_type   out_word_ff;

   logic           advance;
   logic           req_fire;
   logic [1:0]     port_direction;
   evk_result_type result;

   evk_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .port_direction (port_direction)
   );

   // a held byte moves on unless it ends a frame and the result slot is
   // still occupied by a word the sink has not taken
   assign advance   = in_valid_ff && !(in_word_ff.last_byte && out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   evk_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .byte_fire      (advance),
      .byte_word      (in_word_ff),
      .port_direction (port_direction),
      .result         (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // result slot: loads on end of frame, drains when the sink takes it
   always_comb begin
      out_valid_in = out_valid_ff;
      if (result.fire) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff <= req_word;
      end
      if (result.fire) begin
         out_word_ff <= result.word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

/* rtl/evk_checker.sv */
// ----------------------------------------------------------------------------
// evk_checker
// port-level checks on the key extractor, bound to the top level
// ----------------------------------------------------------------------------
module evk_checker
   import evk_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_word_type          rsp_word
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // input never stalls while the result slot is empty
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled with empty result slot");

   // failed frames carry the all-ones key and no ipv6 flag
   a_fail_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != ST_KEY_READY |->
         !rsp_word.is_ipv6 && (&rsp_word.key_high) && (&rsp_word.key_low))
      else $error("failed frame with live key");

   // good frames point at a legal network header offset
   a_good_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_KEY_READY |->
         rsp_word.hdr_offset == 5'd14 || rsp_word.hdr_offset == 5'd18 ||
         rsp_word.hdr_offset == 5'd22)
      else $error("bad l3 offset on good frame");

endmodule

bind eth_vlan_ip_key_extractor_unit evk_checker u_evk_checker (.*);
